>>> src/ptb_pkg.sv
// Shared types and constants of the periodic timer bank.
package ptb_pkg;

  // Operation codes carried by an input word.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_START_WR,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_DONE
  } state_e;

  // Configuration register indexes.
  localparam logic CFG_TICK_PERIOD   = 1'b0;
  localparam logic CFG_TIMERS_IN_USE = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  // Field widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIDX_W     = 4;
  localparam int unsigned TCOUNT_W   = 16;
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned TIU_W      = 5;
  localparam int unsigned DIV_CNT_W  = 5;

  // Reset values of the configuration registers.
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 20'd1000;
  localparam logic [TIU_W-1:0]    TIMERS_RESET      = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic start_write;
    logic walk_init;
    logic walk_write;
    logic walk_next;
    logic finish;
  } ptb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic index_valid;
    logic tick_go;
    logic div_last;
    logic walk_last;
    logic out_free;
  } ptb_sts_t;

endpackage

>>> src/periodic_timer_bank_top.sv
// Top level of the periodic timer bank: controller, datapath and checks.
//
// The block holds NUM_TIMERS periodic timers counted in base ticks. Each input
// word carries an operation (tick, start, stop, check), a timer index, a tick
// count and an interval in microseconds. Every accepted word yields exactly
// one result word with the expired bit, which is only ever set by a check.
// Both channels use valid and stall; a word moves at a clock edge where valid
// is high and stall is low. Configuration is written through a plain write
// port (index 0 tick period in microseconds, index 1 timers in use). The user
// must write it only while the bank is idle; the block does not enforce this.
// One word is worked on at a time. Stop, check and a zero tick go straight
// to the result. A tick walks the timers in use through the timer RAM, with
// a read state and a write state per timer. A start runs a restoring divider
// one quotient bit per cycle.
// The result sits in an output register; a stalled receiver holds it there
// and the next word is accepted meanwhile, its result waiting until the slot
// frees. Reset stops all timers and clears all expiry flags at once.
module periodic_timer_bank_top #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ptb_pkg::OP_W-1:0]       operation_i,
  input  logic [ptb_pkg::TIDX_W-1:0]     timer_index_i,
  input  logic [ptb_pkg::TCOUNT_W-1:0]   tick_count_i,
  input  logic [ptb_pkg::INTERVAL_W-1:0] interval_us_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           expired_o,
  input  logic                           cfg_we_i,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ptb_pkg::*;

  ptb_cmd_t cmd;
  ptb_sts_t sts;

  // The controller sequences each word; the datapath does the work.
  ptb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .timer_index_i (timer_index_i),
    .tick_count_i  (tick_count_i),
    .interval_us_i (interval_us_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .expired_o     (expired_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // Once a word is taken, the bank is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a word was still in progress");

  // A start is written only for an addressable timer.
  a_start_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_write |-> (sts.op == OP_START) && sts.index_valid)
    else $error("timer store written for a start that should be ignored");

  // The tick walk only runs for a nonzero tick.
  a_walk_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_write |-> (sts.op == OP_TICK) && sts.tick_go)
    else $error("timer walk outside a nonzero tick");

  // A result is only loaded into a free output slot.
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !out_valid_o || !out_stall_i)
    else $error("result would overwrite a waiting word");

endmodule

>>> src/ptb_ram.sv
// Generic simple dual-port RAM with a registered read port.
module ptb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ptb_ctrl.sv
// Controller state machine of the periodic timer bank.
module ptb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptb_pkg::ptb_sts_t  sts_i,
  output ptb_pkg::ptb_cmd_t  cmd_o
);
  import ptb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        if (sts_i.op == OP_TICK && sts_i.tick_go) begin
          state_d = ST_TICK_RD;
        end else if (sts_i.op == OP_START && sts_i.index_valid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_START_WR;
      end
      ST_START_WR: state_d = ST_DONE;
      ST_TICK_RD:  state_d = ST_TICK_WR;
      ST_TICK_WR: begin
        state_d = sts_i.walk_last ? ST_DONE : ST_TICK_RD;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.walk_init = (sts_i.op == OP_TICK) && sts_i.tick_go;
        cmd_o.div_init  = (sts_i.op == OP_START) && sts_i.index_valid;
      end
      ST_DIV:      cmd_o.div_step    = 1'b1;
      ST_START_WR: cmd_o.start_write = 1'b1;
      ST_TICK_RD:  ;
      ST_TICK_WR: begin
        cmd_o.walk_write = 1'b1;
        cmd_o.walk_next  = !sts_i.walk_last;
      end
      ST_DONE:     cmd_o.finish = sts_i.out_free;
      default:     ;
    endcase
  end

endmodule

>>> src/ptb_datapath.sv
// Datapath of the periodic timer bank: registers, divider, timer store and flags.
module ptb_datapath #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ptb_pkg::OP_W-1:0]           operation_i,
  input  logic [ptb_pkg::TIDX_W-1:0]         timer_index_i,
  input  logic [ptb_pkg::TCOUNT_W-1:0]       tick_count_i,
  input  logic [ptb_pkg::INTERVAL_W-1:0]     interval_us_i,
  input  logic                               cfg_we_i,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic                               expired_o,
  input  ptb_pkg::ptb_cmd_t                  cmd_i,
  output ptb_pkg::ptb_sts_t                  sts_o
);
  import ptb_pkg::*;

  localparam int unsigned IW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned CmpW = (COUNT_WIDTH > TCOUNT_W) ? COUNT_WIDTH : TCOUNT_W;
  localparam logic [8:0]  NumT = 9'(NUM_TIMERS);
  localparam logic [INTERVAL_W-1:0] CountMax =
    INTERVAL_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  // Captured input word.
  op_e                   op_q;
  logic [TIDX_W-1:0]     tidx_q;
  logic [TCOUNT_W-1:0]   count_q;

  // Configuration.
  logic [PERIOD_W-1:0]   period_q;
  logic [TIU_W-1:0]      tiu_q;

  // Divider: the quotient register is loaded with the interval and shifts it out.
  logic [INTERVAL_W-1:0] quo_q;
  logic [PERIOD_W-1:0]   rem_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;

  // Walk over the timers, per-timer run and expiry bits.
  logic [IW-1:0]         walk_q;
  logic [NUM_TIMERS-1:0] running_q;
  logic [NUM_TIMERS-1:0] flag_q;

  logic                  out_valid_q;
  logic                  expired_q;

  logic [8:0]            active;
  logic                  index_valid;
  logic [8:0]            tidx9;
  logic [IW-1:0]         sidx;
  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W:0]     trial;
  logic [PERIOD_W:0]     diff;
  logic                  ge;
  logic [INTERVAL_W-1:0] qsat;
  logic [CW-1:0]         ticks;
  logic [2*CW-1:0]       rdata;
  logic [CW-1:0]         cur_rem;
  logic [CW-1:0]         cur_reload;
  logic [CmpW-1:0]       rem_ext;
  logic [CmpW-1:0]       cnt_ext;
  logic                  hit;
  logic [CW-1:0]         new_rem;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [2*CW-1:0]       ram_wdata;
  logic                  out_free;

  assign active      = (9'(tiu_q) > NumT) ? NumT : 9'(tiu_q);
  assign tidx9       = 9'(tidx_q);
  assign index_valid = tidx9 < active;
  assign sidx        = tidx9[IW-1:0];

  // One restoring division step per cycle.
  assign period = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign trial  = {rem_q, quo_q[INTERVAL_W-1]};
  assign ge     = trial >= {1'b0, period};
  assign diff   = trial - {1'b0, period};

  assign qsat  = (quo_q > CountMax) ? CountMax : quo_q;
  assign ticks = (qsat == '0) ? CW'(1) : qsat[CW-1:0];

  // Tick update of the timer being walked.
  assign cur_rem    = rdata[CW-1:0];
  assign cur_reload = rdata[2*CW-1:CW];
  assign rem_ext    = CmpW'(cur_rem);
  assign cnt_ext    = CmpW'(count_q);
  assign hit        = rem_ext <= cnt_ext;
  assign new_rem    = hit ? cur_reload : (cur_rem - CW'(cnt_ext));

  assign ram_we    = cmd_i.start_write || (cmd_i.walk_write && running_q[walk_q]);
  assign ram_waddr = cmd_i.start_write ? sidx : walk_q;
  assign ram_wdata = cmd_i.start_write ? {ticks, ticks} : {cur_reload, new_rem};

  ptb_ram #(
    .WIDTH (2 * CW),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (walk_q),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o             = '0;
    sts_o.op          = op_q;
    sts_o.index_valid = index_valid;
    sts_o.tick_go     = (count_q != '0) && (active != '0);
    sts_o.div_last    = div_cnt_q == '1;
    sts_o.walk_last   = 9'(walk_q) == (active - 9'd1);
    sts_o.out_free    = out_free;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      tidx_q  <= timer_index_i;
      count_q <= tick_count_i;
      quo_q   <= interval_us_i;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[INTERVAL_W-2:0], ge};
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end
    if (cmd_i.finish) begin
      expired_q <= (op_q == OP_CHECK) && index_valid && flag_q[sidx];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= TICK_PERIOD_RESET;
      tiu_q       <= TIMERS_RESET;
      div_cnt_q   <= '0;
      walk_q      <= '0;
      running_q   <= '0;
      flag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TICK_PERIOD:   period_q <= cfg_data_i;
          CFG_TIMERS_IN_USE: tiu_q    <= cfg_data_i[TIU_W-1:0];
          default:           ;
        endcase
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.walk_init) begin
        walk_q <= '0;
      end else if (cmd_i.walk_next) begin
        walk_q <= walk_q + IW'(1);
      end
      if (cmd_i.start_write) begin
        running_q[sidx] <= 1'b1;
        flag_q[sidx]    <= 1'b0;
      end
      if (cmd_i.walk_write && running_q[walk_q] && hit) begin
        flag_q[walk_q] <= 1'b1;
      end
      if (cmd_i.finish && index_valid) begin
        if (op_q == OP_STOP)  running_q[sidx] <= 1'b0;
        if (op_q == OP_CHECK) flag_q[sidx]    <= 1'b0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign expired_o   = expired_q;

endmodule
